[rtl/fqd_pkg.sv]
// fqd_pkg: shared types and constants for the FIFO queue with delete by match.
// No dependencies; used by fqd_cell and fifo_queue_with_delete_by_match.
`default_nettype none

package fqd_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned ValueW = 32;
  localparam int unsigned LenW   = 5;

  typedef enum logic [KindW-1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_DEL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic              status;
    logic [ValueW-1:0] data_out;
    logic [LenW-1:0]   length;
  } out_rsp_t;

  // Per-cycle commands broadcast to every cell.
  typedef struct packed {
    logic shift;  // dequeue: every cell takes its neighbor's word
    logic load;   // enqueue: the cell at the tail slot takes the key word
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/fqd_cell.sv]
// fqd_cell: one queue slot. Holds a word, compares it against the key while
// the delete token visits, and shifts in its neighbor's word. Uses fqd_pkg.
`default_nettype none

module fqd_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fqd_pkg::cell_ctl_t    ctl_i,
  input  wire logic [CNT_W-1:0]      count_i,
  input  wire logic [DATA_WIDTH-1:0] key_i,
  input  wire logic [DATA_WIDTH-1:0] nbr_word_i,
  input  wire logic                  tok_i,
  input  wire logic                  car_i,
  output logic [DATA_WIDTH-1:0]      word_o,
  output logic                       tok_o,
  output logic                       car_o
);

  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic                  tok_q, car_q;
  logic                  occupied, is_tail, hit, carry;

  assign occupied = CNT_W'(IDX) < count_i;
  assign is_tail  = CNT_W'(IDX) == count_i;
  assign hit      = tok_q & occupied & (word_q == key_i);
  // once a match is seen at or before this slot, this slot closes the gap
  assign carry    = car_q | hit;

  always_comb begin
    word_d = word_q;
    if (ctl_i.shift) begin
      word_d = nbr_word_i;
    end else if (ctl_i.load && is_tail) begin
      word_d = key_i;
    end else if (tok_q && carry) begin
      word_d = nbr_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      car_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
      car_q <= car_i;
    end
  end

  assign word_o = word_q;
  assign tok_o  = tok_q;
  assign car_o  = carry;

endmodule

`default_nettype wire

[rtl/fifo_queue_with_delete_by_match.sv]
// fifo_queue_with_delete_by_match: bounded FIFO of words with delete of the
// first matching entry. Top level; uses fqd_pkg and a row of fqd_cell slots.
//
//  channel | signals                         | payload
//  --------+---------------------------------+---------------------------
//  in      | in_valid_i / in_ready_o         | in_req_i  (kind, value)
//  out     | out_valid_o / out_ready_i       | out_rsp_o (status, data_out, length)
//
// One request at a time. Enqueue, dequeue and rejected requests pass through
// accept, execute and the response register; a delete with a nonzero key adds a
// sweep state, as a token walks the cell row one slot per cycle carrying the match flag.
// Reset clears the length and all control; slot words stay undefined.
// A new request is accepted once the previous response sits in the output
// register, even if the consumer is stalling it.
`default_nettype none

module fifo_queue_with_delete_by_match #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire fqd_pkg::in_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output fqd_pkg::out_rsp_t     out_rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  fqd_pkg::state_e   state_q, state_d;
  fqd_pkg::in_req_t  req_q, req_d;
  fqd_pkg::out_rsp_t rsp_q, rsp_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              status_q, status_d;
  logic [fqd_pkg::ValueW-1:0] data_q, data_d;
  logic              out_valid_q, out_valid_d;

  fqd_pkg::cell_ctl_t    ctl;
  logic                  sweep_start;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] word_w [DEPTH];
  logic [DEPTH-1:0]      tok_w;
  logic [DEPTH-1:0]      car_w;

  assign key = DATA_WIDTH'(req_q.value);

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;
    logic                  tin, cin;
    if (gi == DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = word_w[gi+1];
    end
    if (gi == 0) begin : g_first
      assign tin = sweep_start;
      assign cin = 1'b0;
    end else begin : g_rest
      assign tin = tok_w[gi-1];
      assign cin = car_w[gi-1];
    end
    fqd_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CntW),
      .IDX       (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .count_i   (count_q),
      .key_i     (key),
      .nbr_word_i(nbr),
      .tok_i     (tin),
      .car_i     (cin),
      .word_o    (word_w[gi]),
      .tok_o     (tok_w[gi]),
      .car_o     (car_w[gi])
    );
  end

  assign in_ready_o = (state_q == fqd_pkg::ST_IDLE);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    status_d    = status_q;
    data_d      = data_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    ctl         = '0;
    sweep_start = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fqd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          state_d = fqd_pkg::ST_EXEC;
        end
      end
      fqd_pkg::ST_EXEC: begin
        status_d = 1'b1;
        data_d   = '0;
        state_d  = fqd_pkg::ST_RESP;
        case (req_q.kind)
          fqd_pkg::KIND_ENQ: begin
            if (key != '0 && count_q < CntW'(DEPTH)) begin
              ctl.load = 1'b1;
              count_d  = count_q + 1'b1;
              status_d = 1'b0;
            end
          end
          fqd_pkg::KIND_DEQ: begin
            if (count_q != '0) begin
              ctl.shift = 1'b1;
              count_d   = count_q - 1'b1;
              status_d  = 1'b0;
              data_d    = fqd_pkg::ValueW'(word_w[0]);
            end
          end
          fqd_pkg::KIND_DEL: begin
            if (key != '0) begin
              sweep_start = 1'b1;
              state_d     = fqd_pkg::ST_SWEEP;
            end
          end
          default: begin
          end
        endcase
      end
      fqd_pkg::ST_SWEEP: begin
        // token leaving the last slot closes the sweep
        if (tok_w[DEPTH-1]) begin
          status_d = ~car_w[DEPTH-1];
          if (car_w[DEPTH-1]) begin
            count_d = count_q - 1'b1;
          end
          state_d = fqd_pkg::ST_RESP;
        end
      end
      fqd_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          rsp_d.status   = status_q;
          rsp_d.data_out = data_q;
          rsp_d.length   = fqd_pkg::LenW'(count_q);
          out_valid_d    = 1'b1;
          state_d        = fqd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fqd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fqd_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    data_q   <= data_d;
    rsp_q    <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue length above depth");

  a_single_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_w))
    else $error("more than one delete token in the cell row");

  a_token_only_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_w != '0) |-> (state_q == fqd_pkg::ST_SWEEP))
    else $error("delete token active outside a sweep");

  a_resp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == fqd_pkg::ST_RESP)
    else $error("response raised without a pending result");

  a_count_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fqd_pkg::ST_IDLE || state_q == fqd_pkg::ST_RESP) |=> $stable(count_q))
    else $error("length changed outside execution");

endmodule

`default_nettype wire

[sim/fifo_queue_with_delete_by_match_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fifo_queue_with_delete_by_match: random and directed
// enqueue/dequeue/delete requests checked against a shadow queue. Needs fqd_pkg and the RTL.

module fifo_queue_with_delete_by_match_tb;

  localparam int unsigned Depth      = 16;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned MaxIdle    = 17;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 1_000_000;
  // Kind code with no operation behind it; the block must reject it.
  localparam logic [fqd_pkg::KindW-1:0] KindUnknown = 2'd3;

  // Shadow of the queue contents plus the responses it predicts.
  class queue_shadow;
    logic [fqd_pkg::ValueW-1:0] slots[$];
    fqd_pkg::out_rsp_t          expected_rsp[$];
    int                         failures = 0;

    function int fill();
      return slots.size();
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function logic [fqd_pkg::ValueW-1:0] slot_at(int idx);
      return slots[idx];
    endfunction

    function void note_request(fqd_pkg::in_req_t req);
      fqd_pkg::out_rsp_t rsp;
      int                hit;
      rsp        = '0;
      rsp.status = 1'b1;
      hit        = -1;
      case (req.kind)
        fqd_pkg::KIND_ENQ: begin
          if (req.value != '0 && slots.size() < Depth) begin
            slots.push_back(req.value);
            rsp.status = 1'b0;
          end
        end
        fqd_pkg::KIND_DEQ: begin
          if (slots.size() != 0) begin
            rsp.data_out = slots.pop_front();
            rsp.status   = 1'b0;
          end
        end
        fqd_pkg::KIND_DEL: begin
          if (req.value != '0) begin
            foreach (slots[i]) begin
              if (hit < 0 && slots[i] == req.value) hit = i;
            end
            if (hit >= 0) begin
              slots.delete(hit);
              rsp.status = 1'b0;
            end
          end
        end
        default: ;
      endcase
      rsp.length = fqd_pkg::LenW'(slots.size());
      expected_rsp.push_back(rsp);
    endfunction

    function void check_response(fqd_pkg::out_rsp_t got);
      fqd_pkg::out_rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("response with nothing outstanding: status %0d data_out %h length %0d",
               got.status, got.data_out, got.length);
        failures++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.data_out !== want.data_out) begin
        $error("data_out mismatch: expected %h, got %h", want.data_out, got.data_out);
        failures++;
      end
      if (got.length !== want.length) begin
        $error("length mismatch: expected %0d, got %0d", want.length, got.length);
        failures++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  fqd_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_ready_i;
  fqd_pkg::out_rsp_t out_rsp_o;

  queue_shadow tracker;
  bit          tx_idle   = 1'b1;
  bit          rx_idle   = 1'b1;
  bit          hold_rx   = 1'b0;
  int unsigned cycle_count = 0;

  fifo_queue_with_delete_by_match #(
    .DEPTH      (Depth),
    .DATA_WIDTH (DataWidth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic fqd_pkg::in_req_t make_req(logic [fqd_pkg::KindW-1:0] kind,
                                                logic [fqd_pkg::ValueW-1:0] value);
    fqd_pkg::in_req_t req;
    req.kind  = kind;
    req.value = value;
    return req;
  endfunction

  // Nonzero word; the small pool makes duplicates likely so delete picks the first.
  function automatic logic [fqd_pkg::ValueW-1:0] rand_word();
    logic [fqd_pkg::ValueW-1:0] w;
    case ($urandom_range(0, 3))
      0: w = fqd_pkg::ValueW'($urandom_range(1, 8));
      1: w = fqd_pkg::ValueW'(1) << $urandom_range(0, fqd_pkg::ValueW - 1);
      2: w = ~(fqd_pkg::ValueW'(1) << $urandom_range(0, fqd_pkg::ValueW - 1));
      default: w = $urandom;
    endcase
    if (w == '0) w = '1;
    return w;
  endfunction

  // Mostly keys that are present, sometimes one that likely is not.
  function automatic logic [fqd_pkg::ValueW-1:0] pick_key();
    if (tracker.fill() > 0 && $urandom_range(0, 4) != 0)
      return tracker.slot_at($urandom_range(0, tracker.fill() - 1));
    return rand_word();
  endfunction

  // Offer one request; valid stays up afterwards so back-to-back requests need no toggle.
  task automatic issue(fqd_pkg::in_req_t req);
    int gap;
    gap = tx_idle ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_request(req);
  endtask

  task automatic random_bursts(int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill to the top, then push into a full queue
          while (tracker.fill() < Depth) begin
            issue(make_req(fqd_pkg::KIND_ENQ, rand_word()));
            sent++;
          end
          repeat ($urandom_range(1, 3)) begin
            issue(make_req(fqd_pkg::KIND_ENQ, rand_word()));
            sent++;
          end
        end
        2: begin
          while (tracker.fill() > 0) begin
            issue(make_req(fqd_pkg::KIND_DEQ, $urandom));
            sent++;
          end
          repeat ($urandom_range(1, 2)) begin
            issue(make_req(fqd_pkg::KIND_DEQ, $urandom));
            sent++;
          end
        end
        3, 4: begin
          repeat ($urandom_range(1, 6)) begin
            issue(make_req(fqd_pkg::KIND_DEL, pick_key()));
            sent++;
          end
        end
        9: begin
          // noise: any kind, any value, zero included
          repeat (4) begin
            issue(make_req(fqd_pkg::KindW'($urandom_range(0, 3)),
                           ($urandom_range(0, 3) == 0) ? '0 : fqd_pkg::ValueW'($urandom)));
            sent++;
          end
        end
        default: begin
          repeat (8) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)      issue(make_req(fqd_pkg::KIND_ENQ, rand_word()));
            else if (pick < 8) issue(make_req(fqd_pkg::KIND_DEQ, $urandom));
            else               issue(make_req(fqd_pkg::KIND_DEL, pick_key()));
            sent++;
          end
        end
      endcase
    end
  endtask

  // The last request is already taken, so valid drops while waiting.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Response side; honors a one-shot long hold when asked.
  initial begin
    int w;
    wait (rst_ni);
    forever begin
      w = rx_idle ? $urandom_range(0, MaxIdle) : 0;
      if (hold_rx) begin
        w       = HoldCycles;
        hold_rx = 1'b0;
      end
      if (w > 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_response(out_rsp_o);
    end
  end

  initial begin
    tracker     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty, null, duplicates, head/middle/tail delete, unknown kind
    issue(make_req(fqd_pkg::KIND_DEQ, '1));
    issue(make_req(fqd_pkg::KIND_DEL, 32'h0000_0001));
    issue(make_req(fqd_pkg::KIND_ENQ, '0));
    issue(make_req(fqd_pkg::KIND_ENQ, 32'hFFFF_FFFF));
    issue(make_req(fqd_pkg::KIND_ENQ, 32'h0000_0001));
    issue(make_req(fqd_pkg::KIND_ENQ, 32'h8000_0000));
    issue(make_req(fqd_pkg::KIND_ENQ, 32'h5555_5555));
    issue(make_req(fqd_pkg::KIND_ENQ, 32'hAAAA_AAAA));
    issue(make_req(fqd_pkg::KIND_ENQ, 32'h0000_0001));
    issue(make_req(fqd_pkg::KIND_DEL, '0));
    issue(make_req(fqd_pkg::KIND_DEL, 32'h0000_1234));
    issue(make_req(fqd_pkg::KIND_DEL, 32'h0000_0001));
    issue(make_req(fqd_pkg::KIND_DEL, 32'h5555_5555));
    issue(make_req(fqd_pkg::KIND_DEL, 32'hFFFF_FFFF));
    issue(make_req(fqd_pkg::KIND_DEL, 32'h0000_0001));
    issue(make_req(KindUnknown, 32'hFFFF_FFFF));
    issue(make_req(fqd_pkg::KIND_DEQ, '0));
    issue(make_req(fqd_pkg::KIND_DEQ, '0));
    issue(make_req(fqd_pkg::KIND_DEQ, '0));

    random_bursts(500);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_bursts(300);

    // back-pressure: consumer stalls while requests keep coming
    wait_drained();
    hold_rx = 1'b1;
    random_bursts(40);

    tx_idle = 1'b1;
    random_bursts(300);

    tx_idle = 1'b0;
    rx_idle = 1'b1;
    random_bursts(300);

    wait_drained();
    repeat (Depth + 8) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fqd_pkg.sv
rtl/fqd_cell.sv
rtl/fifo_queue_with_delete_by_match.sv
sim/fifo_queue_with_delete_by_match_tb.sv
